@@ hw/rtl/shp_pkg.sv @@
package shp_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int CHAN_W       = 8;
   localparam int PIX_W        = 3 * CHAN_W;
   localparam int COL_W        = 10;
   localparam int ROW_W        = 12;
   localparam int WIDTH_W      = 11;
   localparam int HEIGHT_W     = 13;
   localparam int LINE_ADDR_W  = $clog2(MAX_WIDTH);
   localparam int LINE_W       = 2 * PIX_W;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int NUM_SLOTS    = 4;
   localparam int SLOT_IDX_W   = $clog2(NUM_SLOTS);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RESET  = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RESET = HEIGHT_W'(1);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic              done;
   } result_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0]                mask;
      result_type [NUM_SLOTS-1:0]          slot;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } push_type;

   function automatic logic [CHAN_W-1:0] sharpen_chan(
      input logic [CHAN_W-1:0] ctr,
      input logic [CHAN_W-1:0] up,
      input logic [CHAN_W-1:0] dn,
      input logic [CHAN_W-1:0] lf,
      input logic [CHAN_W-1:0] rt
   );
      logic [CHAN_W+3:0] s;
      logic [CHAN_W-1:0] res;
      s = {2'b00, ctr, 2'b00} + {4'b0000, ctr} - {4'b0000, up} - {4'b0000, dn}
        - {4'b0000, lf} - {4'b0000, rt};
      if (s[CHAN_W+3]) begin
         res = '0;
      end else if (s[CHAN_W+2:CHAN_W] != 3'b000) begin
         res = '1;
      end else begin
         res = s[CHAN_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [PIX_W-1:0] sharpen_pixel(
      input logic [PIX_W-1:0] up,
      input logic [PIX_W-1:0] ctr,
      input logic [PIX_W-1:0] dn,
      input logic [PIX_W-1:0] lf,
      input logic [PIX_W-1:0] rt
   );
      logic [PIX_W-1:0] res;
      for (int k = 0; k < 3; k++) begin
         res[k*CHAN_W +: CHAN_W] = sharpen_chan(ctr[k*CHAN_W +: CHAN_W],
            up[k*CHAN_W +: CHAN_W], dn[k*CHAN_W +: CHAN_W],
            lf[k*CHAN_W +: CHAN_W], rt[k*CHAN_W +: CHAN_W]);
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/sharpen_3x3_edge_replicate.sv @@
// 3x3 sharpen (5*center minus the four orthogonal neighbors, per channel,
// clamped to 0..255) over a raster RGB stream, borders replicated. A pixel
// can be taken on every clock while req_stall is low. Each input beat
// yields zero to four result beats, issued one per clock while rsp_stall
// is low from a four-deep result queue, so the result port sets the pace:
// one beat per body pixel, none in the first row of a multi-row frame,
// one extra for a row-end pixel and two for each pixel of the last row.
// The two previous rows live in a single 1024 x 48 line RAM, read at
// accept and written back in the next cycle, bypassed for a one-pixel-wide
// frame. The user must set the frame size through the CSR port only while
// the block is idle, which it does not enforce. A size change restarts at
// pixel (0,0) when the current position falls outside the new frame.
module sharpen_3x3_edge_replicate import shp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CHAN_W-1:0]      req_in_red,
   input  logic [CHAN_W-1:0]      req_in_green,
   input  logic [CHAN_W-1:0]      req_in_blue,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CHAN_W-1:0]      rsp_out_red,
   output logic [CHAN_W-1:0]      rsp_out_green,
   output logic [CHAN_W-1:0]      rsp_out_blue,
   output logic [COL_W-1:0]       rsp_out_column,
   output logic [ROW_W-1:0]       rsp_out_row,
   output logic                   rsp_frame_done
);

   logic [WIDTH_W-1:0]  frame_width_ff;
   logic [HEIGHT_W-1:0] frame_height_ff;
   logic                accept;
   logic                stage_busy;
   logic [QCNT_W-1:0]   queue_count;
   logic [QCNT_W:0]     pending;
   push_type            push;
   result_type          result;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_data[WIDTH_W-1:0];
            end
            REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_data[HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // room for the bundle in stage 1 plus one more
   assign pending   = {1'b0, queue_count} + (QCNT_W+1)'(stage_busy);
   assign req_stall = (pending >= (QCNT_W+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   shp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pixel        ({req_in_red, req_in_green, req_in_blue}),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .push         (push),
      .stage_busy   (stage_busy)
   );

   shp_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_result (result),
      .count      (queue_count)
   );

   assign rsp_out_red    = result.red;
   assign rsp_out_green  = result.green;
   assign rsp_out_blue   = result.blue;
   assign rsp_out_column = result.column;
   assign rsp_out_row    = result.row;
   assign rsp_frame_done = result.done;

endmodule

@@ hw/rtl/shp_ram.sv @@
module shp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/shp_front.sv @@
module shp_front import shp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [PIX_W-1:0]    pixel,
   input  logic [WIDTH_W-1:0]  frame_width,
   input  logic [HEIGHT_W-1:0] frame_height,
   output push_type            push,
   output logic                stage_busy
);

   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [COL_W-1:0]    col_ff, col_in, c0;
   logic [ROW_W-1:0]    row_ff, row_in, r0;
   logic                restart, end0, last0;

   logic                s1_valid_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic [ROW_W-1:0]    s1_row_ff;
   logic                s1_end_ff;
   logic                s1_last_ff;
   logic [PIX_W-1:0]    s1_px_ff;
   logic [COL_W-1:0]    s1_wlast_ff;

   logic                fwd_valid_ff;
   logic [COL_W-1:0]    fwd_addr_ff;
   logic [LINE_W-1:0]   fwd_data_ff;

   logic [LINE_W-1:0]   line_rd, line_wr;
   logic [PIX_W-1:0]    above, two_above;
   logic                fwd_hit;
   logic [2:0][PIX_W-1:0]        col_v;
   logic [2:0][2:0][PIX_W-1:0]   win_ff, win_in, nwin;
   bundle_type          bundle;
   logic [COL_W-1:0]    col_m1;
   logic [ROW_W-1:0]    row_m1;

   // stage 0: position tracking and line store read
   always_comb begin
      if (frame_width == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (frame_width > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = frame_width;
      end
      if (frame_height == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if (frame_height > HEIGHT_W'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height;
      end
      restart = ({1'b0, col_ff} >= w_eff) || ({1'b0, row_ff} >= h_eff);
      c0      = restart ? '0 : col_ff;
      r0      = restart ? '0 : row_ff;
      end0    = ({1'b0, c0} == (w_eff - WIDTH_W'(1)));
      last0   = ({1'b0, r0} == (h_eff - HEIGHT_W'(1)));
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (end0) begin
            col_in = '0;
            row_in = last0 ? '0 : r0 + ROW_W'(1);
         end else begin
            col_in = c0 + COL_W'(1);
            row_in = r0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= accept;
         fwd_valid_ff <= s1_valid_ff;
         win_ff       <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= c0;
         s1_row_ff   <= r0;
         s1_end_ff   <= end0;
         s1_last_ff  <= last0;
         s1_px_ff    <= pixel;
         s1_wlast_ff <= COL_W'(w_eff - WIDTH_W'(1));
      end
      fwd_addr_ff <= s1_col_ff;
      fwd_data_ff <= line_wr;
   end

   shp_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr),
      .rd_en   (accept),
      .rd_addr (c0),
      .rd_data (line_rd)
   );

   // stage 1: window update, line store write back, kernel
   always_comb begin
      fwd_hit   = fwd_valid_ff && (fwd_addr_ff == s1_col_ff);
      above     = fwd_hit ? fwd_data_ff[PIX_W-1:0]      : line_rd[PIX_W-1:0];
      two_above = fwd_hit ? fwd_data_ff[LINE_W-1:PIX_W] : line_rd[LINE_W-1:PIX_W];
      line_wr   = {above, s1_px_ff};

      if (s1_row_ff == '0) begin
         col_v[0] = s1_px_ff;
         col_v[1] = s1_px_ff;
      end else if (s1_row_ff == ROW_W'(1)) begin
         col_v[0] = above;
         col_v[1] = above;
      end else begin
         col_v[0] = two_above;
         col_v[1] = above;
      end
      col_v[2] = s1_px_ff;

      for (int k = 0; k < 3; k++) begin
         if (s1_col_ff == '0) begin
            nwin[k][0] = col_v[k];
            nwin[k][1] = col_v[k];
         end else begin
            nwin[k][0] = win_ff[k][1];
            nwin[k][1] = win_ff[k][2];
         end
         nwin[k][2] = col_v[k];
      end
      win_in = s1_valid_ff ? nwin : win_ff;
   end

   always_comb begin
      col_m1 = s1_col_ff - COL_W'(1);
      row_m1 = s1_row_ff - ROW_W'(1);

      bundle.mask[0] = (s1_row_ff != '0) && (s1_col_ff != '0);
      bundle.mask[1] = (s1_row_ff != '0) && s1_end_ff;
      bundle.mask[2] = s1_last_ff && (s1_col_ff != '0);
      bundle.mask[3] = s1_last_ff && s1_end_ff;

      {bundle.slot[0].red, bundle.slot[0].green, bundle.slot[0].blue} =
         sharpen_pixel(nwin[0][1], nwin[1][1], nwin[2][1], nwin[1][0], nwin[1][2]);
      bundle.slot[0].column = col_m1;
      bundle.slot[0].row    = row_m1;
      bundle.slot[0].done   = 1'b0;

      {bundle.slot[1].red, bundle.slot[1].green, bundle.slot[1].blue} =
         sharpen_pixel(nwin[0][2], nwin[1][2], nwin[2][2], nwin[1][1], nwin[1][2]);
      bundle.slot[1].column = s1_wlast_ff;
      bundle.slot[1].row    = row_m1;
      bundle.slot[1].done   = 1'b0;

      {bundle.slot[2].red, bundle.slot[2].green, bundle.slot[2].blue} =
         sharpen_pixel(nwin[1][1], nwin[2][1], nwin[2][1], nwin[2][0], nwin[2][2]);
      bundle.slot[2].column = col_m1;
      bundle.slot[2].row    = s1_row_ff;
      bundle.slot[2].done   = 1'b0;

      {bundle.slot[3].red, bundle.slot[3].green, bundle.slot[3].blue} =
         sharpen_pixel(nwin[1][2], nwin[2][2], nwin[2][2], nwin[2][1], nwin[2][2]);
      bundle.slot[3].column = s1_wlast_ff;
      bundle.slot[3].row    = s1_row_ff;
      bundle.slot[3].done   = 1'b1;

      push.valid  = s1_valid_ff && (bundle.mask != '0);
      push.bundle = bundle;
   end

   assign stage_busy = s1_valid_ff;

   a_accept_reaches_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted pixel did not reach stage 1");

   a_top_row_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_row_ff == '0) && !s1_last_ff) |-> !push.valid)
      else $error("first row of a multi-row frame produced output");

   a_frame_end_flagged: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && s1_end_ff) |-> (push.valid && push.bundle.mask[3]))
      else $error("last pixel of frame did not produce the closing beat");

endmodule

@@ hw/rtl/shp_out_queue.sv @@
module shp_out_queue import shp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  push_type          push,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output result_type        rsp_result,
   output logic [QCNT_W-1:0] count
);

   bundle_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       head_ff, head_in, tail_ff, tail_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic [NUM_SLOTS-1:0]    sent_ff, sent_in;
   bundle_type              head;
   logic [NUM_SLOTS-1:0]    remaining, sel_onehot;
   logic [SLOT_IDX_W-1:0]   sel;
   logic                    beat, pop;

   always_comb begin
      head      = queue_ff[head_ff];
      remaining = head.mask & ~sent_ff;
      sel       = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (remaining[i]) begin
            sel = SLOT_IDX_W'(i);
         end
      end
      sel_onehot = NUM_SLOTS'(1) << sel;
      rsp_valid  = (count_ff != '0);
      rsp_result = head.slot[sel];
      beat       = rsp_valid && !rsp_stall;
      pop        = beat && ((remaining & ~sel_onehot) == '0);

      sent_in = sent_ff;
      if (pop) begin
         sent_in = '0;
      end else if (beat) begin
         sent_in = sent_ff | sel_onehot;
      end

      head_in  = pop ? head_ff + QPTR_W'(1) : head_ff;
      tail_in  = push.valid ? tail_ff + QPTR_W'(1) : tail_ff;
      count_in = count_ff + QCNT_W'(push.valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         sent_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         sent_ff  <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         queue_ff[tail_ff] <= push.bundle;
      end
   end

   assign count = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> ((count_ff != QCNT_W'(QUEUE_DEPTH)) || pop))
      else $error("result queue overflow");

   a_head_has_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (remaining != '0))
      else $error("queued bundle has no beat left");

   a_pop_clears_sent: assert property (@(posedge clock) disable iff (reset)
      pop |=> (sent_ff == '0))
      else $error("sent mask not cleared after bundle retired");

endmodule

@@ tb/tb.sv @@
module tb;
   import shp_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_HI = 2'd3;
   localparam int RANDOM_PIXELS = 180;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 300;
   localparam int STUCK_LIMIT   = 5000;
   localparam int MAX_REPORTS   = 50;

   class sharpen_shadow;
      logic [WIDTH_W-1:0]  width_reg;
      logic [HEIGHT_W-1:0] height_reg;
      logic [PIX_W-1:0]    above [MAX_WIDTH];
      logic [PIX_W-1:0]    two_above [MAX_WIDTH];
      logic [PIX_W-1:0]    win [3][3];
      int                  col;
      int                  row;
      result_type          due [$];
      int                  mismatches;

      function new();
         width_reg  = FRAME_WIDTH_RESET;
         height_reg = FRAME_HEIGHT_RESET;
         foreach (above[i]) begin
            above[i]     = '0;
            two_above[i] = '0;
         end
         foreach (win[i, j]) win[i][j] = '0;
         col        = 0;
         row        = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == REG_FRAME_WIDTH) begin
            width_reg = data[WIDTH_W-1:0];
         end else if (index == REG_FRAME_HEIGHT) begin
            height_reg = data[HEIGHT_W-1:0];
         end
      endfunction

      function int eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH) return MAX_WIDTH;
         return int'(width_reg);
      endfunction

      function int eff_height();
         if (height_reg == 0) return 1;
         if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
         return int'(height_reg);
      endfunction

      function int frame_pixels();
         return eff_width() * eff_height();
      endfunction

      function result_type sharpen_at(logic [PIX_W-1:0] up, ctr, dn, lf, rt,
                                      int x, int y, bit last);
         result_type        res;
         logic [CHAN_W-1:0] ch [3];
         int                s;
         int                k;
         for (k = 0; k < 3; k++) begin
            s = 5 * int'(ctr[(2-k)*CHAN_W +: CHAN_W]) - int'(up[(2-k)*CHAN_W +: CHAN_W])
              - int'(dn[(2-k)*CHAN_W +: CHAN_W]) - int'(lf[(2-k)*CHAN_W +: CHAN_W])
              - int'(rt[(2-k)*CHAN_W +: CHAN_W]);
            if (s < 0) s = 0;
            if (s > 255) s = 255;
            ch[k] = CHAN_W'(s);
         end
         res.red    = ch[0];
         res.green  = ch[1];
         res.blue   = ch[2];
         res.column = COL_W'(x);
         res.row    = ROW_W'(y);
         res.done   = last;
         return res;
      endfunction

      function void note_pixel(logic [CHAN_W-1:0] red, green, blue);
         int               w, h, c, r, k;
         logic [PIX_W-1:0] px;
         logic [PIX_W-1:0] fresh [3];
         bit               row_end, last_row;
         w = eff_width();
         h = eff_height();
         // position outside a resized frame restarts at (0,0)
         if (col >= w || row >= h) begin
            col = 0;
            row = 0;
         end
         c  = col;
         r  = row;
         px = {red, green, blue};
         fresh[2] = px;
         if (r == 0) begin
            fresh[0] = px;
            fresh[1] = px;
         end else if (r == 1) begin
            fresh[0] = above[c];
            fresh[1] = above[c];
         end else begin
            fresh[0] = two_above[c];
            fresh[1] = above[c];
         end
         for (k = 0; k < 3; k++) begin
            if (c == 0) begin
               win[k][0] = fresh[k];
               win[k][1] = fresh[k];
            end else begin
               win[k][0] = win[k][1];
               win[k][1] = win[k][2];
            end
            win[k][2] = fresh[k];
         end
         two_above[c] = above[c];
         above[c]     = px;
         row_end  = (c == w - 1);
         last_row = (r == h - 1);
         if (r >= 1) begin
            if (c >= 1) begin
               due.push_back(sharpen_at(win[0][1], win[1][1], win[2][1], win[1][0],
                                        win[1][2], c - 1, r - 1, 1'b0));
            end
            if (row_end) begin
               due.push_back(sharpen_at(win[0][2], win[1][2], win[2][2], win[1][1],
                                        win[1][2], w - 1, r - 1, 1'b0));
            end
         end
         if (last_row) begin
            if (c >= 1) begin
               due.push_back(sharpen_at(win[1][1], win[2][1], win[2][1], win[2][0],
                                        win[2][2], c - 1, r, 1'b0));
            end
            if (row_end) begin
               due.push_back(sharpen_at(win[1][2], win[2][2], win[2][2], win[2][1],
                                        win[2][2], w - 1, r, 1'b1));
            end
         end
         col = c + 1;
         if (col >= w) begin
            col = 0;
            row = r + 1;
            if (row >= h) row = 0;
         end
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", what);
      endtask

      task check_pixel(result_type got);
         result_type want;
         if (due.size() == 0) begin
            report($sformatf("unexpected result beat at (%0d,%0d)", got.column, got.row));
         end else begin
            want = due.pop_front();
            if (got.red !== want.red)
               report($sformatf("(%0d,%0d) red %0d, expected %0d",
                                want.column, want.row, got.red, want.red));
            if (got.green !== want.green)
               report($sformatf("(%0d,%0d) green %0d, expected %0d",
                                want.column, want.row, got.green, want.green));
            if (got.blue !== want.blue)
               report($sformatf("(%0d,%0d) blue %0d, expected %0d",
                                want.column, want.row, got.blue, want.blue));
            if (got.column !== want.column)
               report($sformatf("column %0d, expected %0d", got.column, want.column));
            if (got.row !== want.row)
               report($sformatf("row %0d, expected %0d", got.row, want.row));
            if (got.done !== want.done)
               report($sformatf("(%0d,%0d) frame_done %0b, expected %0b",
                                want.column, want.row, got.done, want.done));
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [CHAN_W-1:0]      req_in_red;
   logic [CHAN_W-1:0]      req_in_green;
   logic [CHAN_W-1:0]      req_in_blue;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b1;
   logic [CHAN_W-1:0]      rsp_out_red;
   logic [CHAN_W-1:0]      rsp_out_green;
   logic [CHAN_W-1:0]      rsp_out_blue;
   logic [COL_W-1:0]       rsp_out_column;
   logic [ROW_W-1:0]       rsp_out_row;
   logic                   rsp_frame_done;

   int            send_idle_pct = 30;
   int            recv_idle_pct = 85;
   logic          holding = 1'b0;
   event          hold_off;
   int            stuck_cycles = 0;
   sharpen_shadow shadow;

   sharpen_3x3_edge_replicate DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_done (rsp_frame_done)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= holding || ($urandom_range(99) < recv_idle_pct);
   end

   // long receiver hold-off, started on request
   initial begin
      forever begin
         @(hold_off);
         holding <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            shadow.note_pixel(req_in_red, req_in_green, req_in_blue);
         end
         if (rsp_valid && !rsp_stall) begin
            shadow.check_pixel({rsp_out_red, rsp_out_green, rsp_out_blue,
                                rsp_out_column, rsp_out_row, rsp_frame_done});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   function automatic logic [CHAN_W-1:0] extreme_chan();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom_range(255));
      endcase
   endfunction

   task automatic send_pixel(input logic [CHAN_W-1:0] red, green, blue);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_in_red   <= red;
      req_in_green <= green;
      req_in_blue  <= blue;
      do @(posedge clock); while (req_stall);
   endtask

   // sender pauses until every expected beat is back, then lets the line RAM settle
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (shadow.due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] width_data, height_data,
                            input bit spare);
      logic [CSR_INDEX_W-1:0] spare_index;
      logic [CSR_DATA_W-1:0]  spare_data;
      csr_write <= 1'b1;
      csr_index <= REG_FRAME_WIDTH;
      csr_data  <= width_data;
      @(posedge clock);
      shadow.write_reg(REG_FRAME_WIDTH, width_data);
      csr_index <= REG_FRAME_HEIGHT;
      csr_data  <= height_data;
      @(posedge clock);
      shadow.write_reg(REG_FRAME_HEIGHT, height_data);
      if (spare) begin
         spare_index = $urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI;
         spare_data  = CSR_DATA_W'($urandom);
         csr_index <= spare_index;
         csr_data  <= spare_data;
         @(posedge clock);
         shadow.write_reg(spare_index, spare_data);
      end
      csr_write <= 1'b0;
   endtask

   initial begin
      int random_sent;
      int pixel_count;
      int w_data;
      int h_data;
      bit held;
      shadow       = new();
      random_sent  = 0;
      held         = 1'b0;
      reset        <= 1'b1;
      csr_write    <= 1'b0;
      csr_index    <= REG_FRAME_WIDTH;
      csr_data     <= '0;
      req_valid    <= 1'b0;
      req_in_red   <= '0;
      req_in_green <= '0;
      req_in_blue  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset size: one 1024-wide row, only its start
      send_pixel('1, '1, '1);
      send_pixel('0, '0, '0);
      send_pixel(8'd255, 8'd0, 8'd128);
      settle();
      // width 0 acts as 1; old position falls outside, restart
      configure(13'd0, 13'd3, 1'b1);
      repeat (3) send_pixel(extreme_chan(), extreme_chan(), extreme_chan());
      settle();
      // oversized width clamps to 1024, height 0 acts as 1
      configure('1, '0, 1'b1);
      repeat (2) send_pixel(extreme_chan(), extreme_chan(), extreme_chan());
      settle();
      // still inside row 0, carries on; height clamps to 4096
      configure(13'd3, '1, 1'b0);
      repeat (7) send_pixel(extreme_chan(), extreme_chan(), extreme_chan());
      settle();
      // row 3 is outside a 2x2 frame: restart, then two full frames with wrap
      configure(13'd2, 13'd2, 1'b0);
      repeat (8) send_pixel(extreme_chan(), extreme_chan(), extreme_chan());
      settle();

      while (random_sent < RANDOM_PIXELS) begin
         if (random_sent >= 120) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (random_sent >= 60) begin
            send_idle_pct = 85;
            recv_idle_pct = 30;
         end else begin
            send_idle_pct = 30;
            recv_idle_pct = 85;
         end
         if (!held && random_sent >= 120) begin
            w_data = 8;
            h_data = 4;
         end else if ($urandom_range(7) == 0) begin
            w_data = $urandom_range(13, 40);
            h_data = $urandom_range(1, 2);
         end else begin
            w_data = $urandom_range(0, 10);
            h_data = $urandom_range(0, 6);
         end
         configure(CSR_DATA_W'(w_data), CSR_DATA_W'(h_data), $urandom_range(3) == 0);
         if (!held && random_sent >= 120) begin
            -> hold_off;
            held = 1'b1;
         end
         pixel_count = shadow.frame_pixels() * $urandom_range(1, 2);
         repeat (pixel_count) begin
            send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
         end
         settle();
         random_sent += pixel_count;
      end

      if (shadow.due.size() != 0) shadow.report("result beats missing at end of run");
      if (shadow.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
